[design/generational_handle_table_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle table
// Shared concurrent-assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define GHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants, codes, types and helpers of the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int GHT_SLOT_COUNT = 1024;

  localparam int KIND_W   = 8;
  localparam int GEN_W    = 16;
  localparam int SLOT_W   = KIND_W + GEN_W;
  localparam int HIDX_W   = 16;    // index field of a handle
  localparam int MAP_BITS = 32;    // slots per free-map word
  localparam int MAP_SH   = 5;     // log2 of MAP_BITS
  localparam int LCNT_W   = 11;

  localparam logic [GEN_W-1:0] GEN_START = 16'h0001;
  localparam logic [GEN_W-1:0] GEN_MAX   = 16'hFFFF;

  // item modes
  localparam logic [1:0] MODE_SPAWN   = 2'd0;
  localparam logic [1:0] MODE_DESTROY = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  // free-map operations
  localparam logic [2:0] FM_NONE    = 3'd0;
  localparam logic [2:0] FM_SEEK    = 3'd1;  // read word at hint
  localparam logic [2:0] FM_NEXT    = 3'd2;  // advance hint, read it
  localparam logic [2:0] FM_CLAIM   = 3'd3;  // mark lowest free bit of hint word
  localparam logic [2:0] FM_FETCH   = 3'd4;  // read word holding slot
  localparam logic [2:0] FM_RELEASE = 3'd5;  // clear slot bit, pull hint down
  localparam logic [2:0] FM_CLEAR   = 3'd6;  // reset sweep

  typedef struct packed {
    logic [2:0]        op;
    logic [HIDX_W-1:0] slot;
  } fm_cmd_t;

  typedef struct packed {
    logic              word_full;
    logic [HIDX_W-1:0] free_slot;
  } fm_stat_t;

  // position of the lowest clear bit; zero when none
  function automatic logic [MAP_SH-1:0] lowest_zero(input logic [MAP_BITS-1:0] w);
    logic [MAP_SH-1:0] pos;
    pos = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (!w[i]) pos = MAP_SH'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

[design/ght_ram.sv]
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/ght_free_map.sv]
// ----------------------------------------------------------------------------
// ght_free_map
// Occupancy bitmap in RAM words plus a hint; every word below the hint is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_free_map
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = GHT_SLOT_COUNT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire fm_cmd_t cmd,
  output fm_stat_t     stat
);

  localparam int NWORDS = (SLOT_COUNT + MAP_BITS - 1) / MAP_BITS;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  // invariant: every word below hint is full
  logic [WA_W-1:0]     hint;
  logic [WA_W-1:0]     hint_next;
  logic [WA_W-1:0]     slot_word;
  logic [MAP_SH-1:0]   slot_bit;
  logic                bm_we;
  logic [WA_W-1:0]     bm_waddr;
  logic [MAP_BITS-1:0] bm_wdata;
  logic [WA_W-1:0]     bm_raddr;
  logic [MAP_BITS-1:0] bm_rd;
  logic [MAP_BITS-1:0] masked;
  logic [MAP_SH-1:0]   pos;

  assign slot_word = WA_W'(cmd.slot >> MAP_SH);
  assign slot_bit  = cmd.slot[MAP_SH-1:0];

  // bits past the end of the table count as occupied
  always_comb begin
    for (int b = 0; b < MAP_BITS; b++) begin
      masked[b] = bm_rd[b] |
        (((17'(hint) << MAP_SH) | 17'(b)) >= 17'(SLOT_COUNT));
    end
  end

  assign pos             = lowest_zero(masked);
  assign stat.word_full  = &masked;
  assign stat.free_slot  = HIDX_W'((17'(hint) << MAP_SH) | 17'(pos));

  always_comb begin
    hint_next = hint;
    bm_raddr  = hint;
    bm_we     = 1'b0;
    bm_waddr  = hint;
    bm_wdata  = '0;
    case (cmd.op)
      FM_SEEK: begin
        bm_raddr = hint;
      end
      FM_NEXT: begin
        hint_next = hint + 1'b1;
        bm_raddr  = hint + 1'b1;
      end
      FM_CLAIM: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rd | (MAP_BITS'(1) << pos);
      end
      FM_FETCH: begin
        bm_raddr = slot_word;
      end
      FM_RELEASE: begin
        bm_we    = 1'b1;
        bm_waddr = slot_word;
        bm_wdata = bm_rd & ~(MAP_BITS'(1) << slot_bit);
        if (slot_word < hint) hint_next = slot_word;
      end
      FM_CLEAR: begin
        bm_we     = ({1'b0, cmd.slot} < 17'(NWORDS));
        bm_waddr  = WA_W'(cmd.slot);
        bm_wdata  = '0;
        hint_next = '0;
      end
      default: begin
        hint_next = hint;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hint <= '0;
    end else begin
      hint <= hint_next;
    end
  end

  ght_ram #(
    .WIDTH (MAP_BITS),
    .DEPTH (NWORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rd)
  );

endmodule

`default_nettype wire

[design/generational_handle_table_top.sv]
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Generational slot map: spawn, destroy and alive query on a slot table.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   --------------------  ------------------------------------------
//  item in   start & !busy         mode, new_kind, handle
//  result    done (1-cycle pulse)  status, result_handle, alive, entry_kind,
//                                  live_count
//
// Query and destroy: slot RAM read, then check and, for destroy, write back.
// Spawn: free-map read at the hint, a step past each full 32-slot word met at
// or above it, then claim and slot write; the hint keeps that scan short in
// normal use. Reset runs a clearing pass over every slot RAM address (and the
// free map) with busy high.
// One item at a time; busy stays high until its result pulses on done. The
// receiver cannot stall: done is a strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_table_top_macros.svh"

module generational_handle_table_top
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = GHT_SLOT_COUNT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        mode,
  input  wire logic [KIND_W-1:0] new_kind,
  input  wire logic [31:0]       handle,
  output logic                   done,
  output logic [1:0]             status,
  output logic [31:0]            result_handle,
  output logic                   alive,
  output logic [KIND_W-1:0]      entry_kind,
  output logic [LCNT_W-1:0]      live_count
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;  // reset sweep
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;  // slot / map read data valid
  localparam logic [1:0] S_SPAWN = 2'd3;  // generation of claimed slot valid

  logic [1:0]        state, state_next;
  logic [IDX_W-1:0]  clr_addr;
  logic [CNT_W-1:0]  count, count_next;

  // captured item
  logic [1:0]        mode_q;
  logic [KIND_W-1:0] kind_q;
  logic [31:0]       handle_q;
  logic [IDX_W-1:0]  spawn_idx;

  // result next values
  logic              done_next;
  logic [1:0]        status_next;
  logic [31:0]       rhandle_next;
  logic              alive_next;
  logic [KIND_W-1:0] ekind_next;

  // slot RAM: {kind, generation}
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr;
  logic [SLOT_W-1:0] s_wdata;
  logic [IDX_W-1:0]  s_raddr;
  logic [SLOT_W-1:0] s_rd;

  fm_cmd_t           fm_cmd;
  fm_stat_t          fm_stat;

  logic [KIND_W-1:0] kind_rd;
  logic [GEN_W-1:0]  gen_rd;
  logic [GEN_W-1:0]  gen_inc;
  logic              in_range;
  logic              live;
  logic              accept;

  assign accept  = start & ~busy;
  assign busy    = (state != S_IDLE);
  assign kind_rd = s_rd[SLOT_W-1:GEN_W];
  assign gen_rd  = s_rd[GEN_W-1:0];
  assign gen_inc = (gen_rd == GEN_MAX) ? GEN_START : gen_rd + 1'b1;

  // a handle resolves when its index is in the table, the slot is taken
  // and the generations agree (generation zero never matches)
  assign in_range = ({1'b0, handle_q[HIDX_W-1:0]} < 17'(SLOT_COUNT));
  assign live     = in_range && (kind_rd != '0) && (gen_rd == handle_q[31:HIDX_W]);

  always_comb begin
    state_next   = state;
    count_next   = count;
    done_next    = 1'b0;
    status_next  = STAT_INVALID;
    rhandle_next = '0;
    alive_next   = 1'b0;
    ekind_next   = '0;
    s_we         = 1'b0;
    s_waddr      = IDX_W'(handle_q[HIDX_W-1:0]);
    s_wdata      = '0;
    s_raddr      = IDX_W'(handle_q[HIDX_W-1:0]);
    fm_cmd.op    = FM_NONE;
    fm_cmd.slot  = handle_q[HIDX_W-1:0];

    case (state)
      S_CLEAR: begin
        s_we        = 1'b1;
        s_waddr     = clr_addr;
        s_wdata     = {{KIND_W{1'b0}}, GEN_START};
        fm_cmd.op   = FM_CLEAR;
        fm_cmd.slot = HIDX_W'(clr_addr);
        if (clr_addr == IDX_W'(SLOT_COUNT - 1)) state_next = S_IDLE;
      end

      S_IDLE: begin
        // reads go out on the accept edge
        s_raddr     = IDX_W'(handle[HIDX_W-1:0]);
        fm_cmd.slot = handle[HIDX_W-1:0];
        if (accept) begin
          fm_cmd.op  = (mode == MODE_SPAWN) ? FM_SEEK : FM_FETCH;
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        case (mode_q)
          MODE_SPAWN: begin
            if ((kind_q == '0) || (count == CNT_W'(SLOT_COUNT))) begin
              done_next   = 1'b1;
              status_next = STAT_FAIL;
              state_next  = S_IDLE;
            end else if (fm_stat.word_full) begin
              // a free slot exists above; step to the next word
              fm_cmd.op = FM_NEXT;
            end else begin
              fm_cmd.op  = FM_CLAIM;
              s_raddr    = IDX_W'(fm_stat.free_slot);
              state_next = S_SPAWN;
            end
          end
          MODE_DESTROY: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (live) begin
              status_next = STAT_OK;
              alive_next  = 1'b1;
              ekind_next  = kind_rd;
              s_we        = 1'b1;
              s_wdata     = {{KIND_W{1'b0}}, gen_inc};
              fm_cmd.op   = FM_RELEASE;
              count_next  = count - 1'b1;
            end
          end
          MODE_QUERY: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (live) begin
              status_next = STAT_OK;
              alive_next  = 1'b1;
              ekind_next  = kind_rd;
            end
          end
          default: begin
            // unused mode: invalid, nothing touched
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_SPAWN: begin
        s_we         = 1'b1;
        s_waddr      = spawn_idx;
        s_wdata      = {kind_q, gen_rd};
        count_next   = count + 1'b1;
        done_next    = 1'b1;
        status_next  = STAT_OK;
        rhandle_next = {gen_rd, HIDX_W'(spawn_idx)};
        ekind_next   = kind_q;
        state_next   = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr + 1'b1;
      count    <= count_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      kind_q   <= new_kind;
      handle_q <= handle;
    end
    if (state == S_LOOK) begin
      spawn_idx <= IDX_W'(fm_stat.free_slot);
    end
    status        <= status_next;
    result_handle <= rhandle_next;
    alive         <= alive_next;
    entry_kind    <= ekind_next;
    live_count    <= LCNT_W'(count_next);
  end

  ght_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rd)
  );

  ght_free_map #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_free_map (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fm_cmd),
    .stat (fm_stat)
  );

  // ---- checks ---------------------------------------------------------------
  `GHT_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result while busy")
  `GHT_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted item did not hold busy")
  `GHT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(SLOT_COUNT), "count over size")
  `GHT_ASSERT_NOW(a_alive_ok, clk, rst, done && alive, status == STAT_OK && result_handle == '0, "alive not ok")

endmodule

`default_nettype wire
